// ===== rtl/nrtbs_pkg.sv =====
// Package for the NR transport block size pipeline.
// Holds field widths, register indexes, the MCS and small-size tables and the shared side-data type.
// No dependencies.
`default_nettype none

package nrtbs_pkg;

	localparam int TBS_TABLE_ENTRIES = 93;
	localparam int MAX_PRB = 275;
	localparam int MAX_LAYERS = 4;

	localparam int MCS_W = 5;
	localparam int PRB_W = 9;
	localparam int LAY_W = 3;
	localparam int TBS_W = 20;
	localparam int STAT_W = 2;
	localparam int SYM_W = 4;
	localparam int DMRS_W = 6;
	localparam int OVH_W = 5;
	localparam int CFG_W = 6;
	localparam int IDX_W = 2;

	// Internal datapath widths.
	localparam int X_W = 30;
	localparam int NINFO_W = 21;
	localparam int DEN_W = 14;
	localparam int QUO_W = 12;
	localparam int SMALL_W = 12;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_SYMBOLS = 2'd0;
	localparam logic [IDX_W-1:0] REG_DMRS = 2'd1;
	localparam logic [IDX_W-1:0] REG_OVERHEAD = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RSVD_MCS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_RE = 2'd2;

	localparam logic [X_W-1:0] SMALL_LIMIT_X = 30'd3915776;
	localparam logic [X_W-1:0] OFFSET24_X = 30'd24576;
	localparam logic [7:0] RE_CAP = 8'd156;
	localparam logic [NINFO_W-1:0] FLOOR_LARGE = 21'd3840;
	localparam logic [NINFO_W-1:0] SEG_HIGH_LIMIT = 21'd8424;
	localparam logic [DEN_W-1:0] SEG_LOW_RATE = 14'd3816;
	localparam logic [DEN_W-1:0] SEG_HIGH_RATE = 14'd8424;
	localparam logic [9:0] QUARTER_RATE = 10'd256;

	localparam logic [SMALL_W-1:0] TBS_SMALL [TBS_TABLE_ENTRIES] = '{
		12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96,
		12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152, 12'd160,
		12'd168, 12'd176, 12'd184, 12'd192,
		12'd208, 12'd224, 12'd240, 12'd256, 12'd272, 12'd288, 12'd304, 12'd320,
		12'd336, 12'd352, 12'd368, 12'd384,
		12'd408, 12'd432, 12'd456, 12'd480, 12'd504, 12'd528, 12'd552, 12'd576,
		12'd608, 12'd640, 12'd672, 12'd704, 12'd736, 12'd768,
		12'd808, 12'd848, 12'd888, 12'd928,
		12'd984, 12'd1032, 12'd1064, 12'd1128, 12'd1160, 12'd1192, 12'd1224, 12'd1256,
		12'd1288, 12'd1320, 12'd1352,
		12'd1416, 12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800,
		12'd1864, 12'd1928,
		12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280,
		12'd2408, 12'd2472, 12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856,
		12'd2976, 12'd3104, 12'd3240, 12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
	};

	// Side data that travels with a transaction through the dividers.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic is_small;
		logic bypass;
		logic [SMALL_W-1:0] tbs_small;
		logic [NINFO_W-1:0] ninfo;
		logic [QUO_W-1:0] c;
	} side_t;

	// Code rate times 1024 for MCS table 1; reserved indexes give zero.
	function automatic logic [9:0] mcs_rate(input logic [MCS_W-1:0] m);
		case (m)
			5'd0: return 10'd120;
			5'd1: return 10'd157;
			5'd2: return 10'd193;
			5'd3: return 10'd251;
			5'd4: return 10'd308;
			5'd5: return 10'd379;
			5'd6: return 10'd449;
			5'd7: return 10'd526;
			5'd8: return 10'd602;
			5'd9: return 10'd679;
			5'd10: return 10'd340;
			5'd11: return 10'd378;
			5'd12: return 10'd434;
			5'd13: return 10'd490;
			5'd14: return 10'd553;
			5'd15: return 10'd616;
			5'd16: return 10'd658;
			5'd17: return 10'd438;
			5'd18: return 10'd466;
			5'd19: return 10'd517;
			5'd20: return 10'd567;
			5'd21: return 10'd616;
			5'd22: return 10'd666;
			5'd23: return 10'd719;
			5'd24: return 10'd772;
			5'd25: return 10'd822;
			5'd26: return 10'd873;
			5'd27: return 10'd910;
			5'd28: return 10'd948;
			default: return 10'd0;
		endcase
	endfunction

	// Modulation order for MCS table 1.
	function automatic logic [2:0] mcs_qm(input logic [MCS_W-1:0] m);
		case (m) inside
			[5'd0:5'd9]: return 3'd2;
			[5'd10:5'd16]: return 3'd4;
			[5'd17:5'd28]: return 3'd6;
			default: return 3'd0;
		endcase
	endfunction

	// Position of the highest set bit; zero for a zero input.
	function automatic logic [4:0] floor_log2(input logic [X_W-1:0] v);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < X_W; i++) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nrtbs_front.sv =====
// Front end: resource elements per PRB, table lookups and the N_info product.
// Three register stages. Depends on nrtbs_pkg.
`default_nettype none

module nrtbs_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic in_valid,
	input  wire logic [nrtbs_pkg::MCS_W-1:0] mcs_index,
	input  wire logic [nrtbs_pkg::PRB_W-1:0] prb_count,
	input  wire logic [nrtbs_pkg::LAY_W-1:0] layer_count,
	input  wire logic [nrtbs_pkg::SYM_W-1:0] sym_cfg,
	input  wire logic [nrtbs_pkg::DMRS_W-1:0] dmrs_cfg,
	input  wire logic [nrtbs_pkg::OVH_W-1:0] ovh_cfg,
	output logic out_valid,
	output logic [nrtbs_pkg::X_W-1:0] x,
	output logic [nrtbs_pkg::STAT_W-1:0] status,
	output logic rate_low
);
	import nrtbs_pkg::*;

	logic [7:0] sym12;
	logic signed [9:0] re_prime;
	logic [7:0] re8;
	logic [PRB_W-1:0] prb_sat;
	logic [LAY_W-1:0] lay_sat;
	logic [STAT_W-1:0] stat_c;
	logic [9:0] rate_c;

	logic valid_s1, valid_s2, valid_s3;
	logic [16:0] prod_s1;
	logic [9:0] rate_s1;
	logic [2:0] qm_s1;
	logic [LAY_W-1:0] lay_s1;
	logic [STAT_W-1:0] stat_s1, stat_s2, stat_s3;
	logic low_s1, low_s2, low_s3;
	logic [26:0] prod_s2;
	logic [5:0] ql_s2;
	logic [X_W-1:0] x_s3;
	logic [32:0] prod3;

	// Resource elements per PRB, saturations and status.
	always_comb begin
		sym12 = {1'b0, sym_cfg, 3'b000} + {2'b00, sym_cfg, 2'b00};
		re_prime = $signed({2'b00, sym12}) - $signed({4'b0000, dmrs_cfg})
			- $signed({5'b00000, ovh_cfg});
		re8 = (re_prime > $signed({2'b00, RE_CAP})) ? RE_CAP : re_prime[7:0];
		prb_sat = (prb_count > PRB_W'(MAX_PRB)) ? PRB_W'(MAX_PRB) : prb_count;
		lay_sat = (layer_count > LAY_W'(MAX_LAYERS)) ? LAY_W'(MAX_LAYERS) : layer_count;
		rate_c = mcs_rate(mcs_index);
		if (mcs_index > 5'd28) stat_c = STAT_RSVD_MCS;
		else if (re_prime <= 0 || prb_sat == '0 || lay_sat == '0) stat_c = STAT_NO_RE;
		else stat_c = STAT_OK;
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign prod3 = {6'd0, prod_s2} * {27'd0, ql_s2};

	// Product chain, one multiplier per stage but two in the second stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= {9'd0, re8} * {8'd0, prb_sat};
			rate_s1 <= rate_c;
			qm_s1 <= mcs_qm(mcs_index);
			lay_s1 <= lay_sat;
			stat_s1 <= stat_c;
			low_s1 <= (rate_c <= QUARTER_RATE);

			prod_s2 <= {10'd0, prod_s1} * {17'd0, rate_s1};
			ql_s2 <= {3'd0, qm_s1} * {3'd0, lay_s1};
			stat_s2 <= stat_s1;
			low_s2 <= low_s1;

			x_s3 <= prod3[X_W-1:0];
			stat_s3 <= stat_s2;
			low_s3 <= low_s2;
		end
	end

	assign out_valid = valid_s3;
	assign x = x_s3;
	assign status = stat_s3;
	assign rate_low = low_s3;

endmodule

`default_nettype wire

// ===== rtl/nrtbs_quant.sv =====
// Quantization of N_info: small-size table search and the large-size rounding,
// then the operands of the first segmentation division. Depends on nrtbs_pkg.
`default_nettype none

module nrtbs_quant (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic in_valid,
	input  wire logic [nrtbs_pkg::X_W-1:0] x,
	input  wire logic [nrtbs_pkg::STAT_W-1:0] status,
	input  wire logic rate_low,
	output logic out_valid,
	output logic [nrtbs_pkg::NINFO_W-1:0] num,
	output logic [nrtbs_pkg::DEN_W-1:0] den,
	output nrtbs_pkg::side_t side
);
	import nrtbs_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic [X_W-1:0] x_s1, y_s1;
	logic [4:0] lgs_s1, lgl_s1;
	logic small_s1, small_s2;
	logic low_s1, low_s2;
	logic [STAT_W-1:0] stat_s1, stat_s2;
	logic [NINFO_W-1:0] ninfo_s2;
	logic [NINFO_W-1:0] num_s3;
	logic [DEN_W-1:0] den_s3;
	side_t side_s3;

	logic [4:0] n_small, sh, n_large;
	logic [19:0] ninfo_sm;
	logic [30:0] rnd;
	logic [NINFO_W-1:0] ninfo_lg;
	logic [SMALL_W-1:0] tbs_sel;
	logic [DEN_W-1:0] den_c;
	logic byp_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage two: N'info for both ranges.
	always_comb begin
		n_small = (lgs_s1 < 5'd19) ? 5'd3 : lgs_s1 - 5'd16;
		ninfo_sm = x_s1[29:10] & ~((20'd1 << n_small) - 20'd1);
		if (ninfo_sm < 20'd24) ninfo_sm = 20'd24;
		sh = lgl_s1 - 5'd5;
		n_large = sh - 5'd10;
		rnd = {1'b0, y_s1} + (31'd1 << (sh - 5'd1));
		ninfo_lg = rnd[30:10] & ~((21'd1 << n_large) - 21'd1);
		if (ninfo_lg < FLOOR_LARGE) ninfo_lg = FLOOR_LARGE;
	end

	// Stage three: smallest table entry not below N'info, and the segment size.
	always_comb begin
		tbs_sel = TBS_SMALL[TBS_TABLE_ENTRIES-1];
		for (int i = TBS_TABLE_ENTRIES - 1; i >= 0; i--) begin
			if ({9'd0, TBS_SMALL[i]} >= ninfo_s2) tbs_sel = TBS_SMALL[i];
		end
		if (low_s2) begin
			den_c = SEG_LOW_RATE;
			byp_c = 1'b0;
		end else if (ninfo_s2 > SEG_HIGH_LIMIT) begin
			den_c = SEG_HIGH_RATE;
			byp_c = 1'b0;
		end else begin
			den_c = SEG_LOW_RATE;
			byp_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x;
			y_s1 <= x - OFFSET24_X;
			lgs_s1 <= floor_log2(x);
			lgl_s1 <= floor_log2(x - OFFSET24_X);
			small_s1 <= (x <= SMALL_LIMIT_X);
			low_s1 <= rate_low;
			stat_s1 <= status;

			ninfo_s2 <= small_s1 ? {1'b0, ninfo_sm} : ninfo_lg;
			small_s2 <= small_s1;
			low_s2 <= low_s1;
			stat_s2 <= stat_s1;

			num_s3 <= ninfo_s2 + 21'd23 + {7'd0, den_c};
			den_s3 <= den_c;
			side_s3.status <= stat_s2;
			side_s3.is_small <= small_s2;
			side_s3.bypass <= byp_c;
			side_s3.tbs_small <= tbs_sel;
			side_s3.ninfo <= ninfo_s2;
			side_s3.c <= '0;
		end
	end

	assign out_valid = valid_s3;
	assign num = num_s3;
	assign den = den_s3;
	assign side = side_s3;

endmodule

`default_nettype wire

// ===== rtl/nrtbs_div.sv =====
// Pipelined restoring divider: 12 quotient bits, four per stage over three stages.
// Carries the transaction's side data alongside. Depends on nrtbs_pkg.
`default_nettype none

module nrtbs_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic in_valid,
	input  wire logic [nrtbs_pkg::NINFO_W-1:0] num,
	input  wire logic [nrtbs_pkg::DEN_W-1:0] den,
	input  wire nrtbs_pkg::side_t side_in,
	output logic out_valid,
	output logic [nrtbs_pkg::QUO_W-1:0] quo,
	output nrtbs_pkg::side_t side_out
);
	import nrtbs_pkg::*;

	typedef struct packed {
		logic [NINFO_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_t;

	// Four compare-and-subtract steps, starting at quotient bit top.
	function automatic div_t div_step4(input div_t d, input logic [DEN_W-1:0] dv,
		input int top);
		div_t r;
		logic [25:0] rem;
		logic [25:0] trial;
		r = d;
		rem = {5'd0, d.rem};
		for (int k = 0; k < 4; k++) begin
			trial = {12'd0, dv} << (top - k);
			if (rem >= trial) begin
				rem = rem - trial;
				r.quo[top - k] = 1'b1;
			end
		end
		r.rem = rem[NINFO_W-1:0];
		return r;
	endfunction

	logic valid_s1, valid_s2, valid_s3;
	div_t d_s1, d_s2, d_s3;
	logic [DEN_W-1:0] den_s1, den_s2;
	side_t side_s1, side_s2, side_s3;
	div_t d_init;

	assign d_init = '{rem: num, quo: '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= div_step4(d_init, den, 11);
			den_s1 <= den;
			side_s1 <= side_in;
			d_s2 <= div_step4(d_s1, den_s1, 7);
			den_s2 <= den_s1;
			side_s2 <= side_s1;
			d_s3 <= div_step4(d_s2, den_s2, 3);
			side_s3 <= side_s2;
		end
	end

	assign out_valid = valid_s3;
	assign quo = d_s3.quo;
	assign side_out = side_s3;

endmodule

`default_nettype wire

// ===== rtl/nr_transport_block_size.sv =====
// Top level of the NR transport block size pipeline: configuration registers,
// the two segmentation divisions and the output register. Depends on nrtbs_pkg.
//
// Usage: an input transaction (mcs_index, prb_count, layer_count) is accepted at
// a clock edge where in_valid is high and in_stall is low. One result
// (block_size_bits, status) leaves per input, in order, accepted where out_valid
// is high and out_stall is low. The configuration registers (symbols, DMRS and
// overhead REs per PRB) are written through cfg_write, cfg_index and cfg_data
// while the pipeline holds no transaction.
// From acceptance to out_valid a transaction passes three multiplier stages,
// three quantization stages, two three-stage dividers with one stage between
// them, and the output register. Throughput is one transaction per cycle while
// not stalled. When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads symbols 14, DMRS 0, overhead 0.
`default_nettype none

module nr_transport_block_size (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write,
	input  wire logic [nrtbs_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [nrtbs_pkg::CFG_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [nrtbs_pkg::MCS_W-1:0] mcs_index,
	input  wire logic [nrtbs_pkg::PRB_W-1:0] prb_count,
	input  wire logic [nrtbs_pkg::LAY_W-1:0] layer_count,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [nrtbs_pkg::TBS_W-1:0] block_size_bits,
	output logic [nrtbs_pkg::STAT_W-1:0] status
);
	import nrtbs_pkg::*;

	logic [SYM_W-1:0] sym_q;
	logic [DMRS_W-1:0] dmrs_q;
	logic [OVH_W-1:0] ovh_q;
	logic adv;

	logic fr_valid, fr_low;
	logic [X_W-1:0] fr_x;
	logic [STAT_W-1:0] fr_stat;
	logic qn_valid;
	logic [NINFO_W-1:0] qn_num;
	logic [DEN_W-1:0] qn_den;
	side_t qn_side;
	logic d1_valid;
	logic [QUO_W-1:0] d1_quo;
	side_t d1_side;
	logic valid_s1;
	logic [NINFO_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	side_t side_s1;
	logic d2_valid;
	logic [QUO_W-1:0] d2_quo;
	side_t d2_side;
	logic valid_s2;
	logic [TBS_W-1:0] tbs_s2;
	logic [STAT_W-1:0] stat_s2;

	logic [QUO_W-1:0] c_c;
	logic [14:0] den8;
	side_t side_c;
	logic [26:0] seg_prod;
	logic [26:0] seg_tbs;
	logic [TBS_W-1:0] tbs_c;

	// The pipeline moves whenever the output register is free or being taken.
	assign adv = !valid_s2 || !out_stall;
	assign in_stall = !adv;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= 4'd14;
			dmrs_q <= '0;
			ovh_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SYMBOLS: sym_q <= cfg_data[SYM_W-1:0];
				REG_DMRS: dmrs_q <= cfg_data;
				REG_OVERHEAD: ovh_q <= cfg_data[OVH_W-1:0];
				default: ;
			endcase
		end
	end

	nrtbs_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(in_valid),
		.mcs_index(mcs_index), .prb_count(prb_count), .layer_count(layer_count),
		.sym_cfg(sym_q), .dmrs_cfg(dmrs_q), .ovh_cfg(ovh_q),
		.out_valid(fr_valid), .x(fr_x), .status(fr_stat), .rate_low(fr_low)
	);

	nrtbs_quant u_quant (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(fr_valid),
		.x(fr_x), .status(fr_stat), .rate_low(fr_low),
		.out_valid(qn_valid), .num(qn_num), .den(qn_den), .side(qn_side)
	);

	// First division gives the code block count.
	nrtbs_div u_div_c (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(qn_valid),
		.num(qn_num), .den(qn_den), .side_in(qn_side),
		.out_valid(d1_valid), .quo(d1_quo), .side_out(d1_side)
	);

	// Code block count and the operands of the second division.
	always_comb begin
		c_c = d1_side.bypass ? 12'd1 : d1_quo;
		den8 = {c_c, 3'b000};
		side_c = d1_side;
		side_c.c = c_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= d1_valid;
			valid_s2 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= d1_side.ninfo + 21'd23 + {6'd0, den8};
			den_s1 <= den8[DEN_W-1:0];
			side_s1 <= side_c;
		end
	end

	// Second division gives the bytes per code block.
	nrtbs_div u_div_k (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s1),
		.num(num_s1), .den(den_s1), .side_in(side_s1),
		.out_valid(d2_valid), .quo(d2_quo), .side_out(d2_side)
	);

	// Final size selection.
	always_comb begin
		seg_prod = {12'd0, d2_side.c, 3'b000} * {15'd0, d2_quo};
		seg_tbs = seg_prod - 27'd24;
		if (d2_side.status != STAT_OK) tbs_c = '0;
		else if (d2_side.is_small) tbs_c = {8'd0, d2_side.tbs_small};
		else tbs_c = seg_tbs[TBS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tbs_s2 <= tbs_c;
			stat_s2 <= d2_side.status;
		end
	end

	assign out_valid = valid_s2;
	assign block_size_bits = tbs_s2;
	assign status = stat_s2;

endmodule

`default_nettype wire

// ===== bench/tb_nr_transport_block_size.sv =====
// Testbench for the NR transport block size pipeline.
// Drives random and directed grants with bursty input and a stalling receiver,
// and checks every result against a built-in size predictor. Depends on nrtbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tb_nr_transport_block_size;
	import nrtbs_pkg::*;

	typedef struct packed {
		logic [MCS_W-1:0] mcs;
		logic [PRB_W-1:0] prb;
		logic [LAY_W-1:0] lay;
	} grant_t;

	typedef struct packed {
		logic [TBS_W-1:0] tbs;
		logic [STAT_W-1:0] stat;
	} size_t;

	localparam int LATENCY = 14;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MCS_W-1:0] mcs_index = '0;
	logic [PRB_W-1:0] prb_count = '0;
	logic [LAY_W-1:0] layer_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TBS_W-1:0] block_size_bits;
	logic [STAT_W-1:0] status;

	// Predictor copy of the configuration registers.
	int unsigned sym_cfg = 14;
	int unsigned dmrs_cfg = 0;
	int unsigned ovh_cfg = 0;

	grant_t pending_grants[$];
	size_t expected_sizes[$];
	int mismatches = 0;
	bit stim_done = 1'b0;
	bit hold_input = 1'b0;
	bit in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;

	nr_transport_block_size uut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.mcs_index(mcs_index), .prb_count(prb_count), .layer_count(layer_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.block_size_bits(block_size_bits), .status(status)
	);

	always #6 clk = ~clk;

	function automatic int unsigned log2_floor(longint unsigned v);
		int unsigned r;
		r = 0;
		while (v > 1) begin
			v = v >> 1;
			r++;
		end
		return r;
	endfunction

	function automatic longint unsigned div_up(longint unsigned a, longint unsigned b);
		return (a + b - 1) / b;
	endfunction

	function automatic longint unsigned code_block_size(longint unsigned ninfo,
			longint unsigned seg);
		longint unsigned c;
		c = div_up(ninfo + 24, seg);
		return 8 * c * div_up(ninfo + 24, 8 * c) - 24;
	endfunction

	// Transport block size for one grant under the current configuration.
	function automatic size_t predict_size(grant_t g);
		size_t r;
		longint signed re_prime;
		longint unsigned prb, lay, rate, qm, re, x, y, ninfo, q;
		int n, sh;
		r.tbs = '0;
		r.stat = STAT_OK;
		prb = (g.prb > MAX_PRB) ? MAX_PRB : g.prb;
		lay = (g.lay > MAX_LAYERS) ? MAX_LAYERS : g.lay;
		re_prime = longint'(12 * sym_cfg) - longint'(dmrs_cfg) - longint'(ovh_cfg);
		case (g.mcs) inside
			[0:9]: qm = 2;
			[10:16]: qm = 4;
			default: qm = 6;
		endcase
		case (g.mcs)
			0: rate = 120; 1: rate = 157; 2: rate = 193; 3: rate = 251;
			4: rate = 308; 5: rate = 379; 6: rate = 449; 7: rate = 526;
			8: rate = 602; 9: rate = 679; 10: rate = 340; 11: rate = 378;
			12: rate = 434; 13: rate = 490; 14: rate = 553; 15: rate = 616;
			16: rate = 658; 17: rate = 438; 18: rate = 466; 19: rate = 517;
			20: rate = 567; 21: rate = 616; 22: rate = 666; 23: rate = 719;
			24: rate = 772; 25: rate = 822; 26: rate = 873; 27: rate = 910;
			default: rate = 948;
		endcase
		if (g.mcs >= 29) begin
			r.stat = STAT_RSVD_MCS;
		end else if (re_prime <= 0 || prb == 0 || lay == 0) begin
			r.stat = STAT_NO_RE;
		end else begin
			re = (re_prime > 156) ? 156 : longint'(re_prime);
			x = re * prb * rate * qm * lay;
			if (x <= 64'd3824 << 10) begin
				n = int'(log2_floor(x)) - 16;
				if (n < 3) n = 3;
				ninfo = (x >> (n + 10)) << n;
				if (ninfo < 24) ninfo = 24;
				r.tbs = TBS_SMALL[TBS_TABLE_ENTRIES - 1];
				for (int i = TBS_TABLE_ENTRIES - 1; i >= 0; i--) begin
					if (TBS_SMALL[i] >= ninfo) r.tbs = TBS_SMALL[i];
				end
			end else begin
				y = x - (64'd24 << 10);
				sh = int'(log2_floor(y)) - 5;
				q = (y + (64'd1 << (sh - 1))) >> sh;
				ninfo = q << (sh - 10);
				if (ninfo < 3840) ninfo = 3840;
				if (rate <= 256) r.tbs = TBS_W'(code_block_size(ninfo, 3816));
				else if (ninfo > 8424) r.tbs = TBS_W'(code_block_size(ninfo, 8424));
				else r.tbs = TBS_W'(8 * div_up(ninfo + 24, 8) - 24);
			end
		end
		return r;
	endfunction

	function automatic grant_t rand_grant();
		grant_t g;
		int sel;
		sel = $urandom_range(0, 19);
		g.mcs = (sel == 0) ? MCS_W'($urandom_range(29, 31)) : MCS_W'($urandom_range(0, 28));
		sel = $urandom_range(0, 9);
		if (sel < 6) g.prb = PRB_W'($urandom_range(1, 40));
		else if (sel < 9) g.prb = PRB_W'($urandom_range(1, 275));
		else g.prb = PRB_W'($urandom_range(0, 511));
		g.lay = LAY_W'($urandom_range(0, 7));
		if (g.lay == 0 && $urandom_range(0, 3) != 0) g.lay = 3'd1;
		return g;
	endfunction

	// Input driver: bursts with random gaps, fed from the pending queue.
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			// Transaction not yet taken; hold it.
		end else if (pending_grants.size() == 0 || hold_input) begin
			in_valid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			mcs_index <= pending_grants[0].mcs;
			prb_count <= pending_grants[0].prb;
			layer_count <= pending_grants[0].lay;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 30);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
		// Receiver stalls in phases: free-running, light and heavy.
		stall_phase <= (stall_phase + 1) % 400;
		if (stall_phase < 120) out_stall <= 1'b0;
		else if (stall_phase < 280) out_stall <= ($urandom_range(0, 4) == 0);
		else out_stall <= ($urandom_range(0, 2) != 0);
	end

	// Accepted input: pop it and queue the predicted size.
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			expected_sizes.insert(expected_sizes.size(),
				predict_size(pending_grants.pop_front()));
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_sizes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tbs %0d status %0d", block_size_bits, status);
			end else begin
				size_t e;
				e = expected_sizes.pop_front();
				if (e.tbs !== block_size_bits || e.stat !== status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: tbs exp %0d got %0d, status exp %0d got %0d",
							e.tbs, block_size_bits, e.stat, status);
				end
			end
		end
	end

	task automatic add_grant(grant_t g);
		pending_grants.insert(pending_grants.size(), g);
	endtask

	task automatic wait_drained();
		while (pending_grants.size() != 0 || in_valid || expected_sizes.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_SYMBOLS: sym_cfg = val & 4'hF;
			REG_DMRS: dmrs_cfg = val & 6'h3F;
			default: ovh_cfg = val & 5'h1F;
		endcase
	endtask

	task automatic set_config(int unsigned s, int unsigned d, int unsigned o);
		wait_drained();
		write_reg(REG_SYMBOLS, s);
		write_reg(REG_DMRS, d);
		write_reg(REG_OVERHEAD, o);
	endtask

	initial begin
		grant_t g;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, reserved codes, no resources, segmentation.
		for (int m = 0; m < 32; m += 4) begin
			g.mcs = MCS_W'(m); g.prb = 9'd1; g.lay = 3'd1;
			add_grant(g);
		end
		g = '{mcs: 5'd28, prb: 9'd275, lay: 3'd4}; add_grant(g);
		g = '{mcs: 5'd31, prb: 9'd511, lay: 3'd7}; add_grant(g);
		g = '{mcs: 5'd27, prb: 9'd511, lay: 3'd7}; add_grant(g);
		g = '{mcs: 5'd0, prb: 9'd275, lay: 3'd4}; add_grant(g);
		g = '{mcs: 5'd5, prb: 9'd0, lay: 3'd2}; add_grant(g);
		g = '{mcs: 5'd5, prb: 9'd10, lay: 3'd0}; add_grant(g);
		g = '{mcs: 5'd29, prb: 9'd0, lay: 3'd0}; add_grant(g);
		g = '{mcs: 5'd16, prb: 9'd3, lay: 3'd2}; add_grant(g);
		g = '{mcs: 5'd9, prb: 9'd20, lay: 3'd1}; add_grant(g);
		g = '{mcs: 5'd10, prb: 9'd256, lay: 3'd1}; add_grant(g);

		// Sender pauses with grants still pending until every result has come.
		while (pending_grants.size() > 6) @(negedge clk);
		hold_input = 1'b1;
		while (in_valid || expected_sizes.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
		hold_input = 1'b0;

		// Random phases over several configurations, extremes included.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_config(14, 0, 0);
				1: set_config(1, 48, 18);
				2: set_config(15, 0, 0);
				3: set_config(1, 0, 0);
				4: set_config(4, 30, 18);
				5: set_config(63, 63, 31);
				6: set_config(12, 63, 31);
				default: set_config($urandom_range(1, 14), $urandom_range(0, 48),
					$urandom_range(0, 18));
			endcase
			for (int i = 0; i < 118; i++) add_grant(rand_grant());
		end
		wait_drained();
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (mismatches == 0 && expected_sizes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/nrtbs_pkg.sv
rtl/nrtbs_front.sv
rtl/nrtbs_quant.sv
rtl/nrtbs_div.sv
rtl/nr_transport_block_size.sv
bench/tb_nr_transport_block_size.sv
